### rtl/usmg_pkg.sv
`default_nettype none

package usmg_pkg;

   // Element kinds on the result channel.
   localparam logic [1:0] KIND_VERT = 2'd0;
   localparam logic [1:0] KIND_IDX  = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // Generation phases.
   localparam logic [1:0] PH_VERT = 2'd0;
   localparam logic [1:0] PH_IDX  = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_STACKS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTORS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS  = 2'd2;

   // Serial divider sizes: the widest dividend is sector << 32, the widest
   // divisor is twice a count.
   localparam int DIV_NW = 41;
   localparam int DIV_DW = 10;

   // CORDIC arctangent table in fractions of a full turn (2^32 per turn).
   localparam int ATAN_LEN = 24;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [29:0] ATAN_TURN [ATAN_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861,
      30'd10430,     30'd5215,      30'd2608,      30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81
   };

endpackage

`default_nettype wire

### rtl/usmg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module usmg_div #(
   parameter int NW = 41,
   parameter int DW = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quo
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [NW-1:0] quo_ff;
   logic [DW:0]   trial;
   logic          fits;
   logic [DW:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[NW-1]};
      fits  = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (start) begin
         quo_ff  <= num;
         rem_ff  <= '0;
         den_ff  <= den;
         cnt_ff  <= CW'(NW);
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NW-2:0], fits};
         rem_ff <= fits ? diff[DW-1:0] : trial[DW-1:0];
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

### rtl/usmg_cordic.sv
`default_nettype none

// Rotation CORDIC over the low 30 bits of a turn, then a quadrant fold.
module usmg_cordic #(
   parameter int ITER = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [31:0]  angle,
   output logic              done,
   output logic signed [32:0] cos_out,
   output logic signed [32:0] sin_out
);

   logic signed [32:0] x_ff, y_ff, z_ff;
   logic [4:0]         k_ff;
   logic [1:0]         q_ff;
   logic               busy_ff;
   logic               done_ff;
   logic signed [32:0] dx, dy, at;

   always_comb begin
      dx = y_ff >>> k_ff;
      dy = x_ff >>> k_ff;
      at = $signed({3'b000, usmg_pkg::ATAN_TURN[k_ff]});
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (start) begin
         x_ff    <= usmg_pkg::CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= $signed({3'b000, angle[29:0]});
         q_ff    <= angle[31:30];
         k_ff    <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
         if (k_ff == 5'(ITER - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            k_ff <= k_ff + 5'd1;
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end
   end

   always_comb begin
      unique case (q_ff)
         2'd0: begin cos_out = x_ff;  sin_out = y_ff;  end
         2'd1: begin cos_out = -y_ff; sin_out = x_ff;  end
         2'd2: begin cos_out = -x_ff; sin_out = -y_ff; end
         default: begin cos_out = y_ff; sin_out = -x_ff; end
      endcase
   end

   assign done = done_ff;

endmodule

`default_nettype wire

### rtl/uv_sphere_mesh_generator.sv
`default_nettype none

// UV sphere mesh generator. Each accepted request beat yields one response
// beat: first every vertex (stack by stack, sector by sector), then the flat
// triangle corner list, then "finished" answers. A vertex uses the bit-serial
// divider (two angle and two texel quotients, one bit per cycle) and runs the
// iterative CORDIC twice. Positions that produce no element, where the walk
// moves past a row end or into the corner list or after a configuration
// change between elements, are skipped one step at a time. The request side
// is stalled while an element is being worked out and is free again in the
// cycle after the response register is loaded; a response that is held by
// rsp_stall keeps the next element waiting.
module uv_sphere_mesh_generator #(
   parameter int MAX_STACKS      = 256,
   parameter int MAX_SECTORS     = 256,
   parameter int TRIG_ITERATIONS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_restart,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic             rsp_last,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [16:0]      rsp_tex_u,
   output logic [16:0]      rsp_tex_v,
   output logic [16:0]      rsp_corner,
   input  wire logic        csr_we,
   input  wire logic [usmg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_NORM1 = 4'd1;
   localparam logic [3:0] ST_DIVA  = 4'd2;
   localparam logic [3:0] ST_CORA  = 4'd3;
   localparam logic [3:0] ST_DIVB  = 4'd4;
   localparam logic [3:0] ST_CORB  = 4'd5;
   localparam logic [3:0] ST_MULP  = 4'd6;
   localparam logic [3:0] ST_MULU  = 4'd7;
   localparam logic [3:0] ST_TEXU  = 4'd8;
   localparam logic [3:0] ST_TEXV  = 4'd9;
   localparam logic [3:0] ST_MULK  = 4'd10;
   localparam logic [3:0] ST_IDXV  = 4'd11;
   localparam logic [3:0] ST_NORM2 = 4'd12;
   localparam logic [3:0] ST_FIN   = 4'd13;

   localparam int NW = usmg_pkg::DIV_NW;
   localparam int DW = usmg_pkg::DIV_DW;

   logic [8:0]  cfg_stack_ff, cfg_sector_ff;
   logic [15:0] cfg_radius_ff;
   logic [8:0]  s_eff, c_eff;

   logic [3:0]  state_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [9:0]  stack_ff, stack_in;
   logic [8:0]  sector_ff, sector_in;
   logic [2:0]  corner_ff, corner_in;
   logic        nrm_done;

   logic signed [32:0] cst_ff, sst_ff, cse_ff, sse_ff, ux_ff, uy_ff;
   logic [2:0]         msel_ff;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod, prod_ff, rnd30, rsh;
   logic signed [16:0] pos_sat;

   logic [1:0]         w_kind_ff;
   logic               w_last_ff;
   logic signed [16:0] w_pos_x_ff, w_pos_y_ff, w_pos_z_ff;
   logic [16:0]        w_tex_u_ff, w_tex_v_ff, w_corner_ff;

   logic               rsp_valid_ff, rsp_last_ff;
   logic [1:0]         rsp_kind_ff;
   logic signed [16:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_pos_z_ff;
   logic signed [15:0] rsp_norm_x_ff, rsp_norm_y_ff, rsp_norm_z_ff;
   logic [16:0]        rsp_tex_u_ff, rsp_tex_v_ff, rsp_corner_ff;

   logic          div_go_ff, div_done;
   logic [NW-1:0] div_num_ff, div_quo;
   logic [DW-1:0] div_den_ff;
   logic          cor_go_ff, cor_done;
   logic [31:0]   cor_ang_ff;
   logic signed [32:0] cor_cos, cor_sin;

   logic [19:0] k1, k2, kv;

   usmg_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   usmg_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_go_ff),
      .angle   (cor_ang_ff),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   function automatic logic signed [15:0] to_norm(input logic signed [32:0] u);
      logic signed [33:0] t;
      t = ($signed({u[32], u}) + 34'sd32768) >>> 16;
      if (t > 34'sd16384) begin
         return 16'sd16384;
      end else if (t < -34'sd16384) begin
         return -16'sd16384;
      end
      return t[15:0];
   endfunction

   always_comb begin
      if (cfg_stack_ff == 9'd0) begin
         s_eff = 9'd1;
      end else if (int'(cfg_stack_ff) > MAX_STACKS) begin
         s_eff = 9'(MAX_STACKS);
      end else begin
         s_eff = cfg_stack_ff;
      end
      if (cfg_sector_ff == 9'd0) begin
         c_eff = 9'd1;
      end else if (int'(cfg_sector_ff) > MAX_SECTORS) begin
         c_eff = 9'(MAX_SECTORS);
      end else begin
         c_eff = cfg_sector_ff;
      end
   end

   // One step of skipping positions that produce no element.
   always_comb begin
      nrm_done  = 1'b0;
      phase_in  = phase_ff;
      stack_in  = stack_ff;
      sector_in = sector_ff;
      corner_in = corner_ff;
      if (phase_ff == usmg_pkg::PH_VERT) begin
         if (sector_ff > c_eff) begin
            sector_in = '0;
            stack_in  = stack_ff + 10'd1;
         end else if (stack_ff > {1'b0, s_eff}) begin
            phase_in  = usmg_pkg::PH_IDX;
            stack_in  = '0;
            sector_in = '0;
            corner_in = '0;
         end else begin
            nrm_done = 1'b1;
         end
      end else if (phase_ff == usmg_pkg::PH_IDX) begin
         if (sector_ff >= c_eff) begin
            sector_in = '0;
            stack_in  = stack_ff + 10'd1;
            corner_in = '0;
         end else if (stack_ff >= {1'b0, s_eff}) begin
            phase_in  = usmg_pkg::PH_DONE;
            stack_in  = '0;
            sector_in = '0;
            corner_in = '0;
         end else if (corner_ff >= 3'd6) begin
            corner_in = '0;
            sector_in = sector_ff + 9'd1;
         end else if (corner_ff < 3'd3 && stack_ff == 10'd0) begin
            corner_in = 3'd3;
         end else if (corner_ff >= 3'd3 && stack_ff == {1'b0, s_eff} - 10'd1) begin
            corner_in = 3'd6;
         end else begin
            nrm_done = 1'b1;
         end
      end else begin
         nrm_done = 1'b1;
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      if (state_ff == ST_MULK) begin
         mul_a = $signed({23'd0, stack_ff});
         mul_b = $signed({23'd0, {1'b0, c_eff} + 10'd1});
      end else begin
         unique case (msel_ff)
            3'd0: begin mul_a = cst_ff; mul_b = cse_ff; end
            3'd1: begin mul_a = cst_ff; mul_b = sse_ff; end
            3'd2: begin mul_a = $signed({17'd0, cfg_radius_ff}); mul_b = ux_ff; end
            3'd3: begin mul_a = $signed({17'd0, cfg_radius_ff}); mul_b = uy_ff; end
            default: begin mul_a = $signed({17'd0, cfg_radius_ff}); mul_b = sst_ff; end
         endcase
      end
      prod  = mul_a * mul_b;
      rnd30 = prod_ff + 66'sd536870912;
      rsh   = rnd30 >>> 30;
      if (rsh > 66'sd65535) begin
         pos_sat = 17'sd65535;
      end else if (rsh < -66'sd65535) begin
         pos_sat = -17'sd65535;
      end else begin
         pos_sat = rsh[16:0];
      end
      k1 = prod_ff[19:0] + {11'd0, sector_ff};
      k2 = k1 + {11'd0, c_eff} + 20'd1;
      unique case (corner_ff)
         3'd0: kv = k1;
         3'd1: kv = k2;
         3'd2: kv = k1 + 20'd1;
         3'd3: kv = k1 + 20'd1;
         3'd4: kv = k2;
         default: kv = k2 + 20'd1;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      div_go_ff <= 1'b0;
      cor_go_ff <= 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            usmg_pkg::CSR_STACKS:  cfg_stack_ff  <= csr_wdata[8:0];
            usmg_pkg::CSR_SECTORS: cfg_sector_ff <= csr_wdata[8:0];
            usmg_pkg::CSR_RADIUS:  cfg_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  phase_ff  <= usmg_pkg::PH_VERT;
                  stack_ff  <= '0;
                  sector_ff <= '0;
                  corner_ff <= '0;
               end
               w_kind_ff   <= usmg_pkg::KIND_VERT;
               w_last_ff   <= 1'b0;
               w_pos_x_ff  <= '0;
               w_pos_y_ff  <= '0;
               w_pos_z_ff  <= '0;
               w_tex_u_ff  <= '0;
               w_tex_v_ff  <= '0;
               w_corner_ff <= '0;
               ux_ff       <= '0;
               uy_ff       <= '0;
               sst_ff      <= '0;
               state_ff    <= ST_NORM1;
            end
         end
         ST_NORM1: begin
            if (!nrm_done) begin
               phase_ff  <= phase_in;
               stack_ff  <= stack_in;
               sector_ff <= sector_in;
               corner_ff <= corner_in;
            end else if (phase_ff == usmg_pkg::PH_VERT) begin
               div_go_ff  <= 1'b1;
               div_num_ff <= {stack_ff, 31'd0};
               div_den_ff <= {1'b0, s_eff};
               state_ff   <= ST_DIVA;
            end else if (phase_ff == usmg_pkg::PH_IDX) begin
               state_ff <= ST_MULK;
            end else begin
               w_kind_ff <= usmg_pkg::KIND_DONE;
               state_ff  <= ST_FIN;
            end
         end
         ST_DIVA: begin
            if (div_done) begin
               cor_go_ff  <= 1'b1;
               cor_ang_ff <= 32'h4000_0000 - div_quo[31:0];
               state_ff   <= ST_CORA;
            end
         end
         ST_CORA: begin
            if (cor_done) begin
               cst_ff     <= cor_cos;
               sst_ff     <= cor_sin;
               div_go_ff  <= 1'b1;
               div_num_ff <= {sector_ff, 32'd0};
               div_den_ff <= {1'b0, c_eff};
               state_ff   <= ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (div_done) begin
               cor_go_ff  <= 1'b1;
               cor_ang_ff <= div_quo[31:0];
               state_ff   <= ST_CORB;
            end
         end
         ST_CORB: begin
            if (cor_done) begin
               cse_ff   <= cor_cos;
               sse_ff   <= cor_sin;
               msel_ff  <= '0;
               state_ff <= ST_MULP;
            end
         end
         ST_MULP: begin
            prod_ff  <= prod;
            state_ff <= ST_MULU;
         end
         ST_MULU: begin
            state_ff <= ST_MULP;
            msel_ff  <= msel_ff + 3'd1;
            unique case (msel_ff)
               3'd0: ux_ff <= rsh[32:0];
               3'd1: uy_ff <= rsh[32:0];
               3'd2: w_pos_x_ff <= pos_sat;
               3'd3: w_pos_y_ff <= pos_sat;
               default: begin
                  w_pos_z_ff <= pos_sat;
                  div_go_ff  <= 1'b1;
                  div_num_ff <= NW'({sector_ff, 17'd0}) + NW'(c_eff);
                  div_den_ff <= {c_eff, 1'b0};
                  state_ff   <= ST_TEXU;
               end
            endcase
         end
         ST_TEXU: begin
            if (div_done) begin
               w_tex_u_ff <= div_quo[16:0];
               div_go_ff  <= 1'b1;
               div_num_ff <= NW'({stack_ff, 17'd0}) + NW'(s_eff);
               div_den_ff <= {s_eff, 1'b0};
               state_ff   <= ST_TEXV;
            end
         end
         ST_TEXV: begin
            if (div_done) begin
               w_tex_v_ff <= div_quo[16:0];
               sector_ff  <= sector_ff + 9'd1;
               state_ff   <= ST_NORM2;
            end
         end
         ST_MULK: begin
            prod_ff  <= prod;
            state_ff <= ST_IDXV;
         end
         ST_IDXV: begin
            w_kind_ff   <= usmg_pkg::KIND_IDX;
            w_corner_ff <= kv[16:0];
            corner_ff   <= corner_ff + 3'd1;
            state_ff    <= ST_NORM2;
         end
         ST_NORM2: begin
            if (!nrm_done) begin
               phase_ff  <= phase_in;
               stack_ff  <= stack_in;
               sector_ff <= sector_in;
               corner_ff <= corner_in;
            end else begin
               w_last_ff <= (phase_ff == usmg_pkg::PH_DONE);
               state_ff  <= ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_ff  <= 1'b1;
               rsp_kind_ff   <= w_kind_ff;
               rsp_last_ff   <= w_last_ff;
               rsp_pos_x_ff  <= w_pos_x_ff;
               rsp_pos_y_ff  <= w_pos_y_ff;
               rsp_pos_z_ff  <= w_pos_z_ff;
               rsp_norm_x_ff <= to_norm(ux_ff);
               rsp_norm_y_ff <= to_norm(uy_ff);
               rsp_norm_z_ff <= to_norm(sst_ff);
               rsp_tex_u_ff  <= w_tex_u_ff;
               rsp_tex_v_ff  <= w_tex_v_ff;
               rsp_corner_ff <= w_corner_ff;
               state_ff      <= ST_IDLE;
            end
         end
         default: state_ff <= ST_IDLE;
      endcase
      if (reset) begin
         cfg_stack_ff  <= 9'd16;
         cfg_sector_ff <= 9'd32;
         cfg_radius_ff <= 16'd256;
         state_ff      <= ST_IDLE;
         phase_ff      <= usmg_pkg::PH_VERT;
         stack_ff      <= '0;
         sector_ff     <= '0;
         corner_ff     <= '0;
         msel_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         div_go_ff     <= 1'b0;
         cor_go_ff     <= 1'b0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_pos_x  = rsp_pos_x_ff;
   assign rsp_pos_y  = rsp_pos_y_ff;
   assign rsp_pos_z  = rsp_pos_z_ff;
   assign rsp_norm_x = rsp_norm_x_ff;
   assign rsp_norm_y = rsp_norm_y_ff;
   assign rsp_norm_z = rsp_norm_z_ff;
   assign rsp_tex_u  = rsp_tex_u_ff;
   assign rsp_tex_v  = rsp_tex_v_ff;
   assign rsp_corner = rsp_corner_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not stalled while an element is in work");

   a_done_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == usmg_pkg::KIND_DONE) |->
      (!rsp_last && rsp_corner == 17'd0 && rsp_pos_x == 17'sd0 && rsp_tex_u == 17'd0))
      else $error("finished beat carries nonzero fields");

   a_vertex_no_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == usmg_pkg::KIND_VERT) |-> (rsp_corner == 17'd0))
      else $error("vertex beat carries a corner index");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int N_ITER = 16;
   localparam int MAX_ST = 256;
   localparam int MAX_SE = 256;

   typedef struct packed {
      logic [1:0]         kind;
      logic               last;
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [16:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic [16:0]        corner;
   } mesh_elem_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_restart = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_we = 1'b0;
   logic [usmg_pkg::CSR_IDX_W-1:0] csr_index = usmg_pkg::CSR_STACKS;
   logic [15:0] csr_wdata = '0;
   logic req_stall, rsp_valid, rsp_last;
   logic [1:0] rsp_kind;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [16:0] rsp_tex_u, rsp_tex_v, rsp_corner;

   uv_sphere_mesh_generator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_last(rsp_last), .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z), .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y),
      .rsp_norm_z(rsp_norm_z), .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v),
      .rsp_corner(rsp_corner), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Local copy of the generator's registers and walk state.
   logic [8:0]  cfg_stacks = 9'd16;
   logic [8:0]  cfg_sectors = 9'd32;
   logic [15:0] cfg_radius = 16'd256;
   logic [1:0]  gen_phase = usmg_pkg::PH_VERT;
   int          gen_stack = 0;
   int          gen_sector = 0;
   int          gen_corner = 0;

   mesh_elem_type expected_q[$];
   bit gaps_on = 1'b0;
   int n_sent = 0, n_vert = 0, n_corner = 0, n_done = 0, n_last = 0;
   int n_err = 0;

   function automatic int clamp_count(logic [8:0] v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint sat(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Rotation CORDIC over the low 30 bits, quadrant fold from the top two.
   task automatic sincos(input logic [31:0] turn, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = usmg_pkg::CORDIC_GAIN;
      y = 0;
      z = longint'(turn[29:0]);
      for (int k = 0; k < N_ITER; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(usmg_pkg::ATAN_TURN[k]);
         end else begin
            x += dx; y -= dy; z += longint'(usmg_pkg::ATAN_TURN[k]);
         end
      end
      unique case (turn[31:30])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   // Moves the walk past positions that produce no element for the live counts.
   task automatic settle_walk(input int ns, input int nc);
      forever begin
         if (gen_phase == usmg_pkg::PH_VERT) begin
            if (gen_sector > nc) begin
               gen_sector = 0; gen_stack++;
            end else if (gen_stack > ns) begin
               gen_phase = usmg_pkg::PH_IDX;
               gen_stack = 0; gen_sector = 0; gen_corner = 0;
            end else return;
         end else if (gen_phase == usmg_pkg::PH_IDX) begin
            if (gen_sector >= nc) begin
               gen_sector = 0; gen_stack++; gen_corner = 0;
            end else if (gen_stack >= ns) begin
               gen_phase = usmg_pkg::PH_DONE;
               gen_stack = 0; gen_sector = 0; gen_corner = 0;
            end else if (gen_corner >= 6) begin
               gen_corner = 0; gen_sector++;
            end else if (gen_corner < 3 && gen_stack == 0) begin
               gen_corner = 3;
            end else if (gen_corner >= 3 && gen_stack == ns - 1) begin
               gen_corner = 6;
            end else return;
         end else return;
      end
   endtask

   task automatic predict_element(input bit restart, output mesh_elem_type e);
      int ns, nc;
      longint cst, sst, cse, sse, p, nv;
      longint u[3];
      logic [31:0] a_st, a_se;
      longint k1, k2, v;
      ns = clamp_count(cfg_stacks, MAX_ST);
      nc = clamp_count(cfg_sectors, MAX_SE);
      e = '0;
      if (restart) begin
         gen_phase = usmg_pkg::PH_VERT;
         gen_stack = 0; gen_sector = 0; gen_corner = 0;
      end
      settle_walk(ns, nc);
      if (gen_phase == usmg_pkg::PH_VERT) begin
         a_st = 32'((64'd1 << 30) - ((64'(gen_stack) << 31) / ns));
         a_se = 32'((64'(gen_sector) << 32) / nc);
         sincos(a_st, cst, sst);
         sincos(a_se, cse, sse);
         u[0] = (cst * cse + (64'sd1 <<< 29)) >>> 30;
         u[1] = (cst * sse + (64'sd1 <<< 29)) >>> 30;
         u[2] = sst;
         for (int a = 0; a < 3; a++) begin
            p = sat((longint'(cfg_radius) * u[a] + (64'sd1 <<< 29)) >>> 30, 65535);
            nv = sat((u[a] + (64'sd1 <<< 15)) >>> 16, 16384);
            unique case (a)
               0: begin e.pos_x = 17'(p); e.norm_x = 16'(nv); end
               1: begin e.pos_y = 17'(p); e.norm_y = 16'(nv); end
               default: begin e.pos_z = 17'(p); e.norm_z = 16'(nv); end
            endcase
         end
         e.tex_u = 17'((longint'(gen_sector) * 131072 + nc) / (2 * nc));
         e.tex_v = 17'((longint'(gen_stack) * 131072 + ns) / (2 * ns));
         e.kind = usmg_pkg::KIND_VERT;
         gen_sector = (gen_sector + 1) & 9'h1FF;
      end else if (gen_phase == usmg_pkg::PH_IDX) begin
         k1 = longint'(gen_stack) * (nc + 1) + gen_sector;
         k2 = k1 + nc + 1;
         unique case (gen_corner)
            0: v = k1;
            1: v = k2;
            2, 3: v = k1 + 1;
            4: v = k2;
            default: v = k2 + 1;
         endcase
         e.kind = usmg_pkg::KIND_IDX;
         e.corner = 17'(v);
         gen_corner = (gen_corner + 1) & 7;
      end else begin
         e.kind = usmg_pkg::KIND_DONE;
         return;
      end
      settle_walk(ns, nc);
      e.last = (gen_phase == usmg_pkg::PH_DONE);
   endtask

   function automatic string fmt(mesh_elem_type e);
      return $sformatf(
         "kind=%0d last=%0d pos=(%0d,%0d,%0d) norm=(%0d,%0d,%0d) tex=(%0d,%0d) corner=%0d",
         e.kind, e.last, e.pos_x, e.pos_y, e.pos_z, e.norm_x, e.norm_y, e.norm_z,
         e.tex_u, e.tex_v, e.corner);
   endfunction

   // Both handshakes are judged at the falling edge, between driving edges.
   always @(negedge clock) begin
      mesh_elem_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_kind, rsp_last, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_norm_x,
                 rsp_norm_y, rsp_norm_z, rsp_tex_u, rsp_tex_v, rsp_corner};
         if (expected_q.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("ERROR: unexpected beat %s", fmt(got));
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               n_err++;
               if (n_err <= 10) begin
                  $display("ERROR: mismatch");
                  $display("  expected %s", fmt(want));
                  $display("  actual   %s", fmt(got));
               end
            end
            unique case (want.kind)
               usmg_pkg::KIND_VERT: n_vert++;
               usmg_pkg::KIND_IDX: n_corner++;
               default: n_done++;
            endcase
            if (want.last) n_last++;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(99) < 24);
   end

   // Called at a rising edge; returns at the rising edge that took the beat.
   task automatic send_item(input bit restart);
      mesh_elem_type e;
      if (gaps_on && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 24) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
         @(posedge clock);
      end
      predict_element(restart, e);
      expected_q.insert(expected_q.size(), e);
      n_sent++;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [usmg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      unique case (idx)
         usmg_pkg::CSR_STACKS: cfg_stacks = val[8:0];
         usmg_pkg::CSR_SECTORS: cfg_sectors = val[8:0];
         default: cfg_radius = val;
      endcase
   endtask

   task automatic set_shape(input int st, input int se, input int rad);
      csr_write(usmg_pkg::CSR_STACKS, 16'(st));
      csr_write(usmg_pkg::CSR_SECTORS, 16'(se));
      csr_write(usmg_pkg::CSR_RADIUS, 16'(rad));
   endtask

   // Advances until the mesh finishes, plus tail finished answers.
   task automatic run_mesh(input int tail);
      send_item(1'b1);
      while (gen_phase != usmg_pkg::PH_DONE) send_item(1'b0);
      repeat (tail) send_item(1'b0);
   endtask

   task automatic test_reset_defaults();
      repeat (4) send_item(1'b0);
      send_item(1'b1);
      drain();
   endtask

   task automatic test_shape_extremes();
      set_shape(1, 1, 65535);   // single stack: the final vertex carries last
      run_mesh(2);
      drain();
      set_shape(0, 0, 0);       // zero counts clamp to one
      run_mesh(1);
      drain();
      set_shape(2, 3, 1);
      run_mesh(1);
      drain();
      set_shape(511, 256, 40000);
      repeat (3) send_item(1'b0);
      drain();
      set_shape(256, 511, 65535);
      send_item(1'b1);
      send_item(1'b0);
      drain();
   endtask

   task automatic test_reconfig_midmesh();
      set_shape(3, 4, 300);
      send_item(1'b1);
      repeat (12) send_item(1'b0);
      drain();
      csr_write(usmg_pkg::CSR_SECTORS, 16'd1);   // position now beyond the new bounds
      repeat (6) send_item(1'b0);
      drain();
      csr_write(usmg_pkg::CSR_STACKS, 16'd1);    // index phase cut short
      repeat (3) send_item(1'b0);
      drain();
      csr_write(usmg_pkg::CSR_RADIUS, 16'hFFFF);
      run_mesh(1);
      drain();
   endtask

   task automatic test_random_meshes();
      int st, se, rad, goal, n_mesh;
      goal = n_sent + 900;
      n_mesh = 0;
      while (n_sent < goal) begin
         gaps_on = (n_mesh >= 3);
         st = ($urandom_range(15) == 0) ? $urandom_range(511) : $urandom_range(1, 4);
         se = ($urandom_range(15) == 0) ? $urandom_range(511) : $urandom_range(1, 6);
         if (st > 6 && se > 6) se = $urandom_range(1, 3);
         if (st > 6) st = (st > 256) ? st : $urandom_range(5, 8);
         rad = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535);
         set_shape(st, se, rad);
         if (st > 8 || se > 8) begin
            // Big meshes: only a short run of random beats.
            repeat ($urandom_range(4, 10)) send_item($urandom_range(9) == 0);
         end else begin
            send_item(1'b1);
            while (gen_phase != usmg_pkg::PH_DONE && n_sent < goal + 200) begin
               if (n_mesh == 5 && gen_phase == usmg_pkg::PH_IDX &&
                   expected_q.size() != 0) begin
                  req_valid <= 1'b0;
                  while (expected_q.size() != 0) @(posedge clock);
               end
               send_item($urandom_range(39) == 0);
            end
            repeat ($urandom_range(2)) send_item(1'b0);
         end
         drain();
         n_mesh++;
      end
      gaps_on = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_shape_extremes();
      test_reconfig_midmesh();
      test_random_meshes();
      drain();
      repeat (300) @(posedge clock);
      $display("Sent %0d requests: %0d vertices, %0d corners, %0d finished answers.",
               n_sent, n_vert, n_corner, n_done);
      $display("Mesh ends flagged: %0d, mismatches: %0d, left over: %0d.",
               n_last, n_err, expected_q.size());
      if (n_err == 0 && expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("Timeout with %0d results outstanding.", expected_q.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### uv_sphere_mesh_generator.f
rtl/usmg_pkg.sv
rtl/usmg_div.sv
rtl/usmg_cordic.sv
rtl/uv_sphere_mesh_generator.sv
verif/tb_top.sv
